FILE: hdl/jcr_pkg.sv
// Shared types and constants for the framed joystick command receiver.
// No dependencies; imported by the front, queue, back and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package jcr_pkg;

  localparam logic [7:0] FRAME_STX = 8'h02;
  localparam logic [7:0] FRAME_ETX = 8'h03;

  // Button command codes ('1'..'4')
  localparam logic [7:0] CODE_SET0 = 8'h31;
  localparam logic [7:0] CODE_CLR0 = 8'h32;
  localparam logic [7:0] CODE_SET1 = 8'h33;
  localparam logic [7:0] CODE_CLR1 = 8'h34;

  localparam logic [15:0] JOY_OFFSET = 16'd200;
  localparam logic [6:0]  DEMO_STEP  = 7'd5;
  localparam logic [6:0]  DEMO_MAX   = 7'd100;
  localparam logic [7:0]  REPLY_BIAS = 8'd4;

  localparam logic [2:0] CNT_BUTTON = 3'd1;
  localparam logic [2:0] CNT_JOY    = 3'd4;
  localparam logic [2:0] CNT_MAX    = 3'd5;

  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_TICK = 1'b1;

  localparam logic OUT_REPLY = 1'b0;
  localparam logic OUT_JOY   = 1'b1;

  typedef enum logic {
    CMD_STATUS,
    CMD_JOY
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BEAT_STX,
    BEAT_BUTTONS,
    BEAT_DEMO,
    BEAT_ETX
  } beat_t;

  // One queued command: a status reply snapshot or a decoded joystick pair
  typedef struct packed {
    cmd_kind_t          kind;
    logic [1:0]         buttons;
    logic [6:0]         demo;
    logic signed [15:0] joy_x;
    logic signed [15:0] joy_y;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/jcr_front.sv
// Front end: deframes received bytes, counts ticks and queues commands.
// Depends on jcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jcr_front
  import jcr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        item_accept,
  input  wire logic        item_kind,
  input  wire logic [7:0]  item_byte,
  input  wire logic [15:0] interval_ms,
  output cmd_t             cmd,
  output logic             cmd_push
);

  logic        in_frame_r, in_frame_nxt;
  logic [2:0]  byte_count_r, byte_count_nxt;
  logic [1:0]  buttons_r, buttons_nxt;
  logic [6:0]  demo_r, demo_nxt;
  logic [16:0] elapsed_r, elapsed_nxt;
  logic [7:0]  data_r [4];
  logic        data_we;

  logic [16:0] elapsed_inc;
  logic [6:0]  demo_step;
  logic [15:0] x_sum, y_sum;

  assign elapsed_inc = elapsed_r + 17'd1;
  assign demo_step   = demo_r + DEMO_STEP;
  assign x_sum = {1'b0, data_r[0], 7'b0} + {8'b0, data_r[1]} - JOY_OFFSET;
  assign y_sum = {1'b0, data_r[2], 7'b0} + {8'b0, data_r[3]} - JOY_OFFSET;

  always_comb begin
    in_frame_nxt   = in_frame_r;
    byte_count_nxt = byte_count_r;
    buttons_nxt    = buttons_r;
    demo_nxt       = demo_r;
    elapsed_nxt    = elapsed_r;
    data_we        = 1'b0;
    cmd_push       = 1'b0;
    cmd.kind       = CMD_STATUS;
    cmd.joy_x      = x_sum;
    cmd.joy_y      = y_sum;

    if (item_accept) begin
      if (item_kind == IN_TICK) begin
        if (elapsed_inc > {1'b0, interval_ms}) begin
          demo_nxt    = (demo_step > DEMO_MAX) ? 7'd0 : demo_step;
          elapsed_nxt = 17'd0;
          cmd_push    = 1'b1;
        end else begin
          elapsed_nxt = elapsed_inc;
        end
      end else if (!in_frame_r) begin
        if (item_byte == FRAME_STX) begin
          in_frame_nxt   = 1'b1;
          byte_count_nxt = 3'd0;
        end
      end else if (item_byte == FRAME_ETX) begin
        in_frame_nxt   = 1'b0;
        byte_count_nxt = 3'd0;
        if (byte_count_r == CNT_BUTTON) begin
          unique case (data_r[0])
            CODE_SET0: buttons_nxt = buttons_r | 2'b01;
            CODE_CLR0: buttons_nxt = buttons_r & 2'b10;
            CODE_SET1: buttons_nxt = buttons_r | 2'b10;
            CODE_CLR1: buttons_nxt = buttons_r & 2'b01;
            default:   buttons_nxt = buttons_r;
          endcase
          cmd_push = 1'b1;
        end else if (byte_count_r == CNT_JOY) begin
          cmd.kind = CMD_JOY;
          cmd_push = 1'b1;
        end
      end else if (byte_count_r >= CNT_MAX) begin
        // sixth byte after STX: over-long frame, drop it
        in_frame_nxt   = 1'b0;
        byte_count_nxt = 3'd0;
      end else begin
        data_we        = (byte_count_r < CNT_JOY);
        byte_count_nxt = byte_count_r + 3'd1;
      end
    end

    // reply carries the state after this item's update
    cmd.buttons = buttons_nxt;
    cmd.demo    = demo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      byte_count_r <= 3'd0;
      buttons_r    <= 2'b00;
      demo_r       <= 7'd0;
      elapsed_r    <= 17'd0;
    end else begin
      in_frame_r   <= in_frame_nxt;
      byte_count_r <= byte_count_nxt;
      buttons_r    <= buttons_nxt;
      demo_r       <= demo_nxt;
      elapsed_r    <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_r[byte_count_r[1:0]] <= item_byte;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/jcr_queue.sv
// Small command FIFO between the front end and the reply sequencer.
// Depends on jcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jcr_queue
  import jcr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      not_empty,
  output logic      full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/jcr_back.sv
// Back end: expands queued commands into result items in an output register.
// Depends on jcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jcr_back
  import jcr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  cmd_t                     head,
  input  wire logic                head_valid,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_kind,
  output logic [7:0]               out_byte,
  output logic signed [15:0]       out_x,
  output logic signed [15:0]       out_y,
  output logic                     out_last
);

  logic               valid_r;
  logic               kind_r;
  logic [7:0]         byte_r;
  logic signed [15:0] x_r, y_r;
  logic               last_r;
  beat_t              beat_r, beat_nxt;

  logic       load;
  logic [7:0] beat_byte;
  logic       beat_last;

  assign load = head_valid && (!valid_r || out_ready);

  always_comb begin
    unique case (beat_r)
      BEAT_STX:     beat_byte = FRAME_STX;
      BEAT_BUTTONS: beat_byte = {4'b0, head.buttons, 2'b00} + REPLY_BIAS;
      BEAT_DEMO:    beat_byte = {1'b0, head.demo} + REPLY_BIAS;
      BEAT_ETX:     beat_byte = FRAME_ETX;
      default:      beat_byte = FRAME_ETX;
    endcase
    beat_last = (head.kind == CMD_JOY) || (beat_r == BEAT_ETX);
    pop       = load && beat_last;
    beat_nxt  = beat_r;
    if (load) begin
      beat_nxt = beat_last ? BEAT_STX : beat_t'(beat_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= BEAT_STX;
    end else begin
      beat_r <= beat_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_r <= beat_last;
      if (head.kind == CMD_JOY) begin
        kind_r <= OUT_JOY;
        byte_r <= 8'd0;
        x_r    <= head.joy_x;
        y_r    <= head.joy_y;
      end else begin
        kind_r <= OUT_REPLY;
        byte_r <= beat_byte;
        x_r    <= '0;
        y_r    <= '0;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

FILE: hdl/framed_joystick_command_receiver.sv
// Framed joystick command receiver, top level. Uses jcr_pkg, jcr_front, jcr_queue, jcr_back.
// Path: an accepted item is decoded, queued in jcr_queue, then registered by jcr_back.
// Throughput: one input item per cycle while the command queue has room; the back end emits
//   one result per cycle while out_tready is high: a status reply is four, a joystick one.
// Reset: synchronous active-low rst_n clears deframer, buttons, demo, tick count,
//   queue and output valid; interval_ms returns to 1000.
`timescale 1ns / 1ps
`default_nettype none

module framed_joystick_command_receiver
  import jcr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] kind (0 byte, 1 tick)
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] tx_byte, [23:8] joy_x, [39:24] joy_y
  output logic             out_tuser,  // [0] out_kind (0 reply byte, 1 joystick)
  output logic             out_tlast,
  // configuration (APB style)
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [15:0] interval_r;
  logic        cfg_wr;

  logic        item_accept;
  cmd_t        front_cmd;
  logic        front_push;
  cmd_t        q_head;
  logic        q_not_empty;
  logic        q_full;
  logic        back_pop;

  logic               res_kind;
  logic [7:0]         res_byte;
  logic signed [15:0] res_x, res_y;

  // --- configuration: single register interval_ms at byte address 0
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, interval_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 16'd1000;
    end else if (cfg_wr && !cfg_paddr[2]) begin
      interval_r <= cfg_pwdata[15:0];
    end
  end

  // --- front end: takes every item while the queue has a free slot
  assign in_tready   = !q_full;
  assign item_accept = in_tvalid && in_tready;

  jcr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_accept (item_accept),
    .item_kind   (in_tuser),
    .item_byte   (in_tdata),
    .interval_ms (interval_r),
    .cmd         (front_cmd),
    .cmd_push    (front_push)
  );

  // --- command queue decouples deframing from reply sequencing
  jcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_cmd  (front_cmd),
    .pop       (back_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // --- back end: one result per cycle into the output register while out_tready is high
  jcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_not_empty),
    .pop        (back_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (res_kind),
    .out_byte   (res_byte),
    .out_x      (res_x),
    .out_y      (res_y),
    .out_last   (out_tlast)
  );

  assign out_tuser = res_kind;
  assign out_tdata = {res_y, res_x, res_byte};

endmodule

`default_nettype wire
